// ===== hdl/kpc_pkg.sv =====
// ----------------------------------------------------------------------------
// kpc_pkg
// Shared types, codes and constants of the keyed Polybius square codec.
// ----------------------------------------------------------------------------
package kpc_pkg;

    localparam int ALPHABET_SIZE = 26;
    localparam int GRID_COLUMNS  = 5;

    // grid index and fill count widths
    localparam int POS_W = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);

    // accumulator holds (row-1)*GRID_COLUMNS + (col-1) for any 3-bit row
    localparam int ACC_RAW_W = $clog2(7 * GRID_COLUMNS);
    localparam int ACC_A_W   = (ACC_RAW_W > POS_W) ? ACC_RAW_W : POS_W;
    localparam int ACC_W     = (ACC_A_W > CNT_W) ? ACC_A_W : CNT_W;

    localparam int LETTER_W = 5;

    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    typedef enum logic [1:0] {
        REQ_KEY  = 2'd0,
        REQ_FILL = 2'd1,
        REQ_ENC  = 2'd2,
        REQ_DEC  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        KIND_PAIR  = 2'd0,
        KIND_SPACE = 2'd1,
        KIND_CHAR  = 2'd2
    } kind_t;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic             ge;
    } alu_res_t;

    typedef struct packed {
        logic                hit;
        logic [LETTER_W-1:0] idx;
    } letter_t;

    function automatic letter_t letter_index(input logic [7:0] c);
        letter_t r;
        r.hit = 1'b0;
        r.idx = '0;
        if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
        begin
            r.hit = 1'b1;
            r.idx = LETTER_W'(c - CHAR_UPPER_A);
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
        begin
            r.hit = 1'b1;
            r.idx = LETTER_W'(c - CHAR_LOWER_A);
        end
        return r;
    endfunction

endpackage

// ===== hdl/kpc_ram.sv =====
// ----------------------------------------------------------------------------
// kpc_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module kpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/kpc_alu.sv =====
// ----------------------------------------------------------------------------
// kpc_alu
// Shared step unit: adds or subtracts one grid row width, compares against it.
// ----------------------------------------------------------------------------
module kpc_alu (
    input  logic [kpc_pkg::ACC_W-1:0] a,
    input  kpc_pkg::alu_op_t          op,
    output kpc_pkg::alu_res_t         res
);

    localparam logic [kpc_pkg::ACC_W-1:0] STEP = kpc_pkg::ACC_W'(kpc_pkg::GRID_COLUMNS);

    always_comb
    begin
        res.ge = (a >= STEP);
        unique case (op)
            kpc_pkg::ALU_ADD: res.value = a + STEP;
            kpc_pkg::ALU_SUB: res.value = a - STEP;
            default:          res.value = a;
        endcase
    end

endmodule

// ===== hdl/keyed_polybius_codec_unit.sv =====
// ----------------------------------------------------------------------------
// keyed_polybius_codec_unit
// Keyed Polybius square codec: key build, encrypt and decrypt of one item.
//
// A request is transferred at a rising edge with start high and busy low.
// At most one result follows, shown for exactly one cycle with valid high.
// Behaviour per request:
//   key character   no result
//   key end fill    one letter slot per cycle, no result
//   encrypt space   result in the next cycle
//   encrypt letter  one table read of the grid index, then repeated subtraction
//                   of GRID_COLUMNS in the step unit
//   decrypt space   result in the next cycle
//   decrypt pair    repeated addition in the step unit, then one table read
//                   for a filled position; no result otherwise
// Results appear in the same cycle in which busy falls (or after the transfer for
// requests that never raise busy). The receiver cannot stall; results are never held.
// Reset clears the placement flags, fill count and completion flag; the
// letter table is invalid until written.
// ----------------------------------------------------------------------------
module keyed_polybius_codec_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] req_type,
    input  logic [7:0] char_code,
    input  logic [2:0] row_in,
    input  logic [2:0] col_in,
    output logic       valid,
    output logic [1:0] kind,
    output logic [2:0] row_out,
    output logic [2:0] col_out,
    output logic [7:0] char_out
);

    localparam int AS    = kpc_pkg::ALPHABET_SIZE;
    localparam int POS_W = kpc_pkg::POS_W;
    localparam int CNT_W = kpc_pkg::CNT_W;
    localparam int ACC_W = kpc_pkg::ACC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILL,
        S_LP_RD,
        S_DIV,
        S_MUL,
        S_PL_RD
    } state_t;

    state_t              state_reg,    state_next;
    logic [AS-1:0]       placed_reg,   placed_next;
    logic [CNT_W-1:0]    count_reg,    count_next;
    logic                complete_reg, complete_next;
    logic [POS_W-1:0]    fill_idx_reg, fill_idx_next;
    logic [ACC_W-1:0]    acc_reg,      acc_next;
    logic [2:0]          step_reg,     step_next;
    logic                valid_reg,    valid_next;
    kpc_pkg::kind_t      kind_reg,     kind_next;
    logic [2:0]          row_reg,      row_next;
    logic [2:0]          col_reg,      col_next;
    logic [7:0]          char_reg,     char_next;

    kpc_pkg::letter_t    letter;
    logic [POS_W-1:0]    letter_addr;
    logic                letter_ok;
    logic                room;

    logic                lp_we;
    logic [POS_W-1:0]    lp_waddr;
    logic [POS_W-1:0]    lp_wdata;
    logic [POS_W-1:0]    lp_rdata;
    logic                pl_we;
    logic [POS_W-1:0]    pl_waddr;
    logic [POS_W-1:0]    pl_wdata;
    logic [POS_W-1:0]    pl_rdata;

    kpc_pkg::alu_op_t    alu_op;
    kpc_pkg::alu_res_t   alu_res;

    // grid index of each letter; meaningful only where placed
    kpc_ram #(
        .WIDTH (POS_W),
        .DEPTH (AS)
    ) u_lp_ram (
        .clk   (clk),
        .we    (lp_we),
        .waddr (lp_waddr),
        .wdata (lp_wdata),
        .raddr (letter_addr),
        .rdata (lp_rdata)
    );

    // letter at each grid index; entries below the fill count are valid
    kpc_ram #(
        .WIDTH (POS_W),
        .DEPTH (AS)
    ) u_pl_ram (
        .clk   (clk),
        .we    (pl_we),
        .waddr (pl_waddr),
        .wdata (pl_wdata),
        .raddr (acc_reg[POS_W-1:0]),
        .rdata (pl_rdata)
    );

    kpc_alu u_alu (
        .a   (acc_reg),
        .op  (alu_op),
        .res (alu_res)
    );

    assign letter      = kpc_pkg::letter_index(char_code);
    assign letter_addr = letter.idx[POS_W-1:0];
    assign letter_ok   = letter.hit && (int'(letter.idx) < AS);
    assign room        = (int'(count_reg) < AS);

    always_comb
    begin
        state_next    = state_reg;
        placed_next   = placed_reg;
        count_next    = count_reg;
        complete_next = complete_reg;
        fill_idx_next = fill_idx_reg;
        acc_next      = acc_reg;
        step_next     = step_reg;
        valid_next    = 1'b0;
        kind_next     = kind_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        char_next     = char_reg;

        lp_we    = 1'b0;
        lp_waddr = letter_addr;
        lp_wdata = count_reg[POS_W-1:0];
        pl_we    = 1'b0;
        pl_waddr = count_reg[POS_W-1:0];
        pl_wdata = letter_addr;
        alu_op   = kpc_pkg::ALU_SUB;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (kpc_pkg::req_t'(req_type))
                        kpc_pkg::REQ_KEY:
                        begin
                            if (!complete_reg && letter_ok && room
                                && !placed_reg[letter_addr])
                            begin
                                lp_we                    = 1'b1;
                                pl_we                    = 1'b1;
                                placed_next[letter_addr] = 1'b1;
                                count_next               = count_reg + 1'b1;
                            end
                        end
                        kpc_pkg::REQ_FILL:
                        begin
                            if (!complete_reg)
                            begin
                                fill_idx_next = '0;
                                state_next    = S_FILL;
                            end
                        end
                        kpc_pkg::REQ_ENC:
                        begin
                            if (char_code == kpc_pkg::CHAR_SPACE)
                            begin
                                valid_next = 1'b1;
                                kind_next  = kpc_pkg::KIND_SPACE;
                                row_next   = '0;
                                col_next   = '0;
                                char_next  = '0;
                            end
                            else if (letter_ok && placed_reg[letter_addr])
                            begin
                                state_next = S_LP_RD;
                            end
                        end
                        kpc_pkg::REQ_DEC:
                        begin
                            if (row_in == 3'd0)
                            begin
                                valid_next = 1'b1;
                                kind_next  = kpc_pkg::KIND_CHAR;
                                row_next   = '0;
                                col_next   = '0;
                                char_next  = kpc_pkg::CHAR_SPACE;
                            end
                            else if (col_in != 3'd0
                                     && int'(col_in) <= kpc_pkg::GRID_COLUMNS)
                            begin
                                acc_next   = ACC_W'(col_in - 3'd1);
                                step_next  = row_in - 3'd1;
                                state_next = S_MUL;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FILL:
            begin
                lp_waddr = fill_idx_reg;
                pl_wdata = fill_idx_reg;
                if (!placed_reg[fill_idx_reg] && room)
                begin
                    lp_we                     = 1'b1;
                    pl_we                     = 1'b1;
                    placed_next[fill_idx_reg] = 1'b1;
                    count_next                = count_reg + 1'b1;
                end
                if (int'(fill_idx_reg) == AS - 1)
                begin
                    complete_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    fill_idx_next = fill_idx_reg + 1'b1;
                end
            end

            S_LP_RD:
            begin
                acc_next   = ACC_W'(lp_rdata);
                step_next  = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                alu_op = kpc_pkg::ALU_SUB;
                if (alu_res.ge)
                begin
                    acc_next  = alu_res.value;
                    step_next = step_reg + 3'd1;
                end
                else
                begin
                    valid_next = 1'b1;
                    kind_next  = kpc_pkg::KIND_PAIR;
                    row_next   = step_reg + 3'd1;
                    col_next   = 3'(acc_reg + 1'b1);
                    char_next  = '0;
                    state_next = S_IDLE;
                end
            end

            S_MUL:
            begin
                alu_op = kpc_pkg::ALU_ADD;
                if (step_reg != 3'd0)
                begin
                    acc_next  = alu_res.value;
                    step_next = step_reg - 3'd1;
                end
                else if (acc_reg < ACC_W'(count_reg) && int'(acc_reg) < AS)
                begin
                    state_next = S_PL_RD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end

            S_PL_RD:
            begin
                valid_next = 1'b1;
                kind_next  = kpc_pkg::KIND_CHAR;
                row_next   = '0;
                col_next   = '0;
                char_next  = kpc_pkg::CHAR_UPPER_A + 8'(pl_rdata);
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            placed_reg   <= '0;
            count_reg    <= '0;
            complete_reg <= 1'b0;
            fill_idx_reg <= '0;
            acc_reg      <= '0;
            step_reg     <= '0;
            valid_reg    <= 1'b0;
            kind_reg     <= kpc_pkg::KIND_PAIR;
            row_reg      <= '0;
            col_reg      <= '0;
            char_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            placed_reg   <= placed_next;
            count_reg    <= count_next;
            complete_reg <= complete_next;
            fill_idx_reg <= fill_idx_next;
            acc_reg      <= acc_next;
            step_reg     <= step_next;
            valid_reg    <= valid_next;
            kind_reg     <= kind_next;
            row_reg      <= row_next;
            col_reg      <= col_next;
            char_reg     <= char_next;
        end
    end

    assign busy     = (state_reg != S_IDLE);
    assign valid    = valid_reg;
    assign kind     = kind_reg;
    assign row_out  = row_reg;
    assign col_out  = col_reg;
    assign char_out = char_reg;

endmodule
